// ===== design/input_queued_switch_random_arbiter_defines.svh =====
// Assertion macros used by the switch RTL.
`ifndef INPUT_QUEUED_SWITCH_RANDOM_ARBITER_DEFINES_SVH
`define INPUT_QUEUED_SWITCH_RANDOM_ARBITER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define IQSRA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define IQSRA_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== design/iqsra_pkg.sv =====
`timescale 1ns / 1ps
package iqsra_pkg;

   localparam int unsigned DEF_PORT_LIMIT = 8;
   localparam int unsigned DEF_MAX_DEPTH  = 16;

   localparam int unsigned LFSR_W = 16;
   localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

   localparam logic [3:0]  ACTIVE_RESET = 4'd8;
   localparam logic [4:0]  DEPTH_RESET  = 5'd4;
   localparam logic [15:0] SEED_RESET   = 16'd44257;

   localparam logic [1:0] CSR_ACTIVE_PORTS = 2'd0;
   localparam logic [1:0] CSR_BUFFER_DEPTH = 2'd1;
   localparam logic [1:0] CSR_RANDOM_SEED  = 2'd2;

   localparam logic MODE_ARRIVAL  = 1'b0;
   localparam logic MODE_SLOT_END = 1'b1;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_PORT = 2'd2;

   typedef struct packed {
      logic       mode;
      logic [2:0] in_port;
      logic [2:0] to_port;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic        sent;
      logic [31:0] pkt_num;
      logic [2:0]  src_port;
      logic [2:0]  dst_port;
      logic [31:0] arrival_slot;
      logic [31:0] delay_slots;
      logic        last;
   } rsp_type;

   // One queued packet as held in the queue memory.
   typedef struct packed {
      logic [31:0] pkt_num;
      logic [31:0] arrival_slot;
      logic [2:0]  destination;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_HREAD,
      ST_HLOAD,
      ST_OUT,
      ST_REM,
      ST_PICK,
      ST_FETCH,
      ST_SEND
   } state_type;

   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
      logic [LFSR_W-1:0] s;
      s = v >> 1;
      if (v[0]) begin
         s = s ^ LFSR_MASK;
      end
      return s;
   endfunction

endpackage

// ===== design/iqsra_store.sv =====
`timescale 1ns / 1ps
module iqsra_store #(
   parameter int unsigned DEPTH  = 128,
   parameter int unsigned ADDR_W = 7
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  iqsra_pkg::entry_type  wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output iqsra_pkg::entry_type  rd_data
);
   import iqsra_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/iqsra_rem.sv =====
`timescale 1ns / 1ps
module iqsra_rem #(
   parameter int unsigned DIV_W = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [iqsra_pkg::LFSR_W-1:0]   dividend,
   input  logic [DIV_W-1:0]               divisor,
   output logic                           done,
   output logic [DIV_W-1:0]               remainder
);
   import iqsra_pkg::*;

   localparam int unsigned STEP_W = $clog2(LFSR_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LFSR_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W:0]    trial;

   // Restoring remainder, one dividend bit per cycle, msb first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quo_ff[LFSR_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = DIV_W'(trial);
         end
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == STEP_W'(LFSR_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/input_queued_switch_random_arbiter.sv =====
`timescale 1ns / 1ps
// Input-queued crossbar switch with random contention resolution. Packets sit
// in one queue memory (one region per input port, read data registered); head
// pointers and fill counts are flip-flops. An accepted arrival is held in a
// register, and its acknowledgement is registered once the result side is
// free; the switch then returns to idle for the next item. A slot end first
// reads each active head (a read state, then a load state, per port), then
// walks the outputs: an idle output is reported directly, a single contender
// is found by a walk over the inputs, fetched and sent, and a contested output
// first waits on the LFSR remainder unit, which works one bit per cycle. Any
// result can stall on the result side. Items are taken one at a time.
module input_queued_switch_random_arbiter #(
   parameter int unsigned PORT_LIMIT = iqsra_pkg::DEF_PORT_LIMIT,
   parameter int unsigned MAX_DEPTH  = iqsra_pkg::DEF_MAX_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  iqsra_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output iqsra_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import iqsra_pkg::*;

   `include "input_queued_switch_random_arbiter_defines.svh"

   localparam int unsigned PORT_W = (PORT_LIMIT > 1) ? $clog2(PORT_LIMIT) : 1;
   localparam int unsigned PCNT_W = $clog2(PORT_LIMIT + 1);
   localparam int unsigned PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int unsigned FILL_W = $clog2(MAX_DEPTH + 1);
   localparam int unsigned SUM_W  = FILL_W + 1;
   localparam int unsigned STORE  = PORT_LIMIT * MAX_DEPTH;
   localparam int unsigned ADDR_W = $clog2(STORE);
   localparam int unsigned CW     = (PCNT_W > 3) ? PCNT_W : 3;
   localparam int unsigned AW     = (PCNT_W > 4) ? PCNT_W : 4;
   localparam int unsigned DW     = (FILL_W > 5) ? FILL_W : 5;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [3:0]         active_ff, active_in;
   logic [4:0]         depth_ff, depth_in;
   logic [LFSR_W-1:0]  lfsr_ff, lfsr_in;
   logic [31:0]        slot_ff, slot_in;
   logic [31:0]        nid_ff, nid_in;
   logic [PTR_W-1:0]   head_ff [PORT_LIMIT];
   logic [PTR_W-1:0]   head_in [PORT_LIMIT];
   logic [FILL_W-1:0]  fill_ff [PORT_LIMIT];
   logic [FILL_W-1:0]  fill_in [PORT_LIMIT];
   logic [2:0]         hdest_ff [PORT_LIMIT];
   logic [2:0]         hdest_in [PORT_LIMIT];
   logic [PORT_LIMIT-1:0] hhas_ff, hhas_in;
   logic [PORT_LIMIT-1:0] mask_ff, mask_in;
   logic [PCNT_W-1:0]  idx_ff, idx_in;
   logic [PCNT_W-1:0]  k_ff, k_in;
   logic [PORT_W-1:0]  j_ff, j_in;
   logic [PORT_W-1:0]  w_ff, w_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [PCNT_W-1:0]  ports_use;
   logic [FILL_W-1:0]  depth_use;
   logic [AW-1:0]      act_w;
   logic [DW-1:0]      dep_w;
   logic               out_free;
   logic [PORT_LIMIT-1:0] mask_now;
   logic [PCNT_W-1:0]  cnt_now;
   logic               last_out;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   entry_type          wr_data, rd_data;

   logic               rem_start, rem_done;
   logic [LFSR_W-1:0]  rem_dividend;
   logic [PCNT_W-1:0]  rem_result;

   logic [PORT_W-1:0]  ap;
   logic               bad, full;
   logic [SUM_W-1:0]   tail_sum;
   logic [PTR_W-1:0]   tail_off;
   logic [PORT_W-1:0]  scan_p;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [PORT_W-1:0] p,
                                                   input logic [PTR_W-1:0] off);
      return ADDR_W'(ADDR_W'(p) * ADDR_W'(MAX_DEPTH) + ADDR_W'(off));
   endfunction

   iqsra_store #(
      .DEPTH  (STORE),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   iqsra_rem #(
      .DIV_W (PCNT_W)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (cnt_now),
      .done      (rem_done),
      .remainder (rem_result)
   );

   // Clamp the register values into the supported ranges.
   always_comb begin
      act_w = AW'(active_ff);
      dep_w = DW'(depth_ff);
      if (act_w == '0) begin
         ports_use = PCNT_W'(1);
      end else if (act_w > AW'(PORT_LIMIT)) begin
         ports_use = PCNT_W'(PORT_LIMIT);
      end else begin
         ports_use = PCNT_W'(act_w);
      end
      if (dep_w == '0) begin
         depth_use = FILL_W'(1);
      end else if (dep_w > DW'(MAX_DEPTH)) begin
         depth_use = FILL_W'(MAX_DEPTH);
      end else begin
         depth_use = FILL_W'(dep_w);
      end
   end

   always_comb begin
      for (int i = 0; i < PORT_LIMIT; i++) begin
         mask_now[i] = hhas_ff[i] && (CW'(hdest_ff[i]) == CW'(idx_ff));
      end
      cnt_now = PCNT_W'($countones(mask_now));
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_out = (PCNT_W'(idx_ff + 1'b1) == ports_use);
   assign scan_p   = PORT_W'(idx_ff);

   // Arrival checks on the held item.
   always_comb begin
      ap   = PORT_W'(req_ff.in_port);
      bad  = (CW'(req_ff.in_port) >= CW'(ports_use)) ||
             (CW'(req_ff.to_port) >= CW'(ports_use));
      full = fill_ff[ap] >= depth_use;
      tail_sum = SUM_W'(head_ff[ap]) + SUM_W'(fill_ff[ap]);
      if (tail_sum >= SUM_W'(MAX_DEPTH)) begin
         tail_off = PTR_W'(tail_sum - SUM_W'(MAX_DEPTH));
      end else begin
         tail_off = PTR_W'(tail_sum);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      active_in    = active_ff;
      depth_in     = depth_ff;
      lfsr_in      = lfsr_ff;
      slot_in      = slot_ff;
      nid_in       = nid_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      hdest_in     = hdest_ff;
      hhas_in      = hhas_ff;
      mask_in      = mask_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = cell_addr(ap, tail_off);
      wr_data      = '{pkt_num: nid_ff, arrival_slot: slot_ff,
                       destination: req_ff.to_port};
      rd_en        = 1'b0;
      rd_addr      = cell_addr(scan_p, head_ff[scan_p]);
      rem_start    = 1'b0;
      rem_dividend = lfsr_step(lfsr_ff);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               if (req_data.mode == MODE_ARRIVAL) begin
                  state_in = ST_ARRIVE;
               end else begin
                  idx_in   = '0;
                  hhas_in  = '0;
                  state_in = ST_HREAD;
               end
            end
         end
         ST_ARRIVE: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.kind         = KIND_ACK;
               rsp_in.src_port     = req_ff.in_port;
               rsp_in.dst_port     = req_ff.to_port;
               rsp_in.arrival_slot = slot_ff;
               rsp_in.last         = 1'b1;
               if (bad) begin
                  rsp_in.status = STATUS_BAD_PORT;
               end else if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status    = STATUS_OK;
                  rsp_in.pkt_num   = nid_ff;
                  wr_en            = 1'b1;
                  fill_in[ap]      = FILL_W'(fill_ff[ap] + 1'b1);
                  nid_in           = nid_ff + 32'd1;
               end
               state_in = ST_IDLE;
            end
         end
         ST_HREAD: begin
            rd_en    = 1'b1;
            state_in = ST_HLOAD;
         end
         ST_HLOAD: begin
            hdest_in[scan_p] = rd_data.destination;
            hhas_in[scan_p]  = (fill_ff[scan_p] != '0);
            if (last_out) begin
               idx_in   = '0;
               state_in = ST_OUT;
            end else begin
               idx_in   = PCNT_W'(idx_ff + 1'b1);
               state_in = ST_HREAD;
            end
         end
         ST_OUT: begin
            mask_in = mask_now;
            j_in    = '0;
            k_in    = '0;
            if (cnt_now == '0) begin
               if (out_free) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in          = '0;
                  rsp_in.kind     = KIND_REPORT;
                  rsp_in.dst_port = 3'(idx_ff);
                  rsp_in.last     = last_out;
                  if (last_out) begin
                     slot_in  = slot_ff + 32'd1;
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = PCNT_W'(idx_ff + 1'b1);
                  end
               end
            end else if (cnt_now == PCNT_W'(1)) begin
               state_in = ST_PICK;
            end else begin
               lfsr_in   = lfsr_step(lfsr_ff);
               rem_start = 1'b1;
               state_in  = ST_REM;
            end
         end
         ST_REM: begin
            if (rem_done) begin
               k_in     = rem_result;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            // Walk the contenders until the chosen one is reached.
            if (mask_ff[j_ff]) begin
               if (k_ff == '0) begin
                  w_in     = j_ff;
                  state_in = ST_FETCH;
               end else begin
                  k_in = PCNT_W'(k_ff - 1'b1);
               end
            end
            j_in = PORT_W'(j_ff + 1'b1);
         end
         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = cell_addr(w_ff, head_ff[w_ff]);
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.kind         = KIND_REPORT;
               rsp_in.status       = STATUS_OK;
               rsp_in.sent         = 1'b1;
               rsp_in.pkt_num      = rd_data.pkt_num;
               rsp_in.src_port     = 3'(w_ff);
               rsp_in.dst_port     = 3'(idx_ff);
               rsp_in.arrival_slot = rd_data.arrival_slot;
               rsp_in.delay_slots  = slot_ff + 32'd1 - rd_data.arrival_slot;
               rsp_in.last         = last_out;
               if (head_ff[w_ff] == PTR_W'(MAX_DEPTH - 1)) begin
                  head_in[w_ff] = '0;
               end else begin
                  head_in[w_ff] = PTR_W'(head_ff[w_ff] + 1'b1);
               end
               fill_in[w_ff] = FILL_W'(fill_ff[w_ff] - 1'b1);
               if (last_out) begin
                  slot_in  = slot_ff + 32'd1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = PCNT_W'(idx_ff + 1'b1);
                  state_in = ST_OUT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      csr_ready = 1'b1;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_PORTS: active_in = csr_data[3:0];
            CSR_BUFFER_DEPTH: depth_in  = csr_data[4:0];
            CSR_RANDOM_SEED:  lfsr_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= ACTIVE_RESET;
         depth_ff     <= DEPTH_RESET;
         lfsr_ff      <= SEED_RESET;
         slot_ff      <= '0;
         nid_ff       <= 32'd1;
         hhas_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PORT_LIMIT; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         depth_ff     <= depth_in;
         lfsr_ff      <= lfsr_in;
         slot_ff      <= slot_in;
         nid_ff       <= nid_in;
         hhas_ff      <= hhas_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      hdest_ff <= hdest_in;
      mask_ff  <= mask_in;
      idx_ff   <= idx_in;
      k_ff     <= k_in;
      j_ff     <= j_in;
      w_ff     <= w_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `IQSRA_CHECK(a_pick_ok, (state_ff == ST_FETCH) |-> mask_ff[w_ff], "bad winner")
   `IQSRA_CHECK(a_send_nonempty, (state_ff == ST_SEND) |-> (fill_ff[w_ff] != '0), "empty send")
   `IQSRA_CHECK(a_lfsr_live, (lfsr_ff != '0 && !csr_valid) |=> (lfsr_ff != '0), "LFSR zero")

endmodule
